FILE: design/ecgfsd_pkg.sv
package ecgfsd_pkg;

    localparam int WORD_W   = 24;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 32;
    localparam int KIND_W   = 3;
    localparam int LEAD_W   = 2;
    localparam int CLS_W    = 3;
    localparam int TAG_W    = 3;

    // status word bit positions
    localparam int DATA_READY_BIT = 23;
    localparam int OVERFLOW_BIT   = 22;
    localparam int DC_LEADOFF_BIT = 20;
    localparam int PLL_BIT        = 8;

    // FIFO word layout
    localparam int TAG_LSB    = 3;
    localparam int SAMPLE_LSB = 8;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int OUT_DATA_W = 216;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SKIPPED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BURST_END = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OPENED    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NO_DATA   = 3'd5;

    // lead states
    localparam logic [LEAD_W-1:0] LEAD_UNKNOWN = 2'd0;
    localparam logic [LEAD_W-1:0] LEAD_ON      = 2'd1;
    localparam logic [LEAD_W-1:0] LEAD_OFF     = 2'd2;

    // FIFO tags
    localparam logic [TAG_W-1:0] TAG_VALID      = 3'd0;
    localparam logic [TAG_W-1:0] TAG_FAST       = 3'd1;
    localparam logic [TAG_W-1:0] TAG_VALID_LAST = 3'd2;
    localparam logic [TAG_W-1:0] TAG_FAST_LAST  = 3'd3;
    localparam logic [TAG_W-1:0] TAG_INVALID_A  = 3'd4;
    localparam logic [TAG_W-1:0] TAG_INVALID_B  = 3'd5;
    localparam logic [TAG_W-1:0] TAG_EMPTY      = 3'd6;
    localparam logic [TAG_W-1:0] TAG_OVERFLOW   = 3'd7;

    // classes the front end sorts FIFO words into
    localparam logic [CLS_W-1:0] CLS_SAMPLE      = 3'd0;
    localparam logic [CLS_W-1:0] CLS_SAMPLE_LAST = 3'd1;
    localparam logic [CLS_W-1:0] CLS_FAST        = 3'd2;
    localparam logic [CLS_W-1:0] CLS_CLOSE       = 3'd3;
    localparam logic [CLS_W-1:0] CLS_EMPTY       = 3'd4;
    localparam logic [CLS_W-1:0] CLS_TAG_OVF     = 3'd5;

    typedef struct packed {
        logic                is_fifo;
        logic                pll;
        logic                ovf;
        logic                drdy;
        logic                pos;
        logic                neg;
        logic                dc;
        logic [CLS_W-1:0]    cls;
        logic [SAMPLE_W-1:0] sample;
    } ecgfsd_op_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ecgfsd_qstat_t;

endpackage

FILE: design/ecgfsd_front.sv
module ecgfsd_front
    import ecgfsd_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,  // word[23:0]
    input  logic                s_tuser,  // command: 0 status, 1 FIFO word
    input  ecgfsd_qstat_t       qstat,
    output logic                push,
    output ecgfsd_op_t          op
);

    logic [TAG_W-1:0] tag;

    assign tag      = s_tdata[TAG_LSB +: TAG_W];
    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

    always_comb begin
        op.is_fifo = s_tuser;
        op.pll     = s_tdata[PLL_BIT];
        op.ovf     = s_tdata[OVERFLOW_BIT];
        op.drdy    = s_tdata[DATA_READY_BIT];
        op.pos     = s_tdata[3] | s_tdata[2];
        op.neg     = s_tdata[1] | s_tdata[0];
        op.dc      = s_tdata[DC_LEADOFF_BIT];
        // 18-bit sample floor-shifted by 2 is just the top 16 bits
        op.sample  = s_tdata[SAMPLE_LSB +: SAMPLE_W];
        unique case (tag)
            TAG_VALID:      op.cls = CLS_SAMPLE;
            TAG_VALID_LAST: op.cls = CLS_SAMPLE_LAST;
            TAG_FAST:       op.cls = CLS_FAST;
            TAG_EMPTY:      op.cls = CLS_EMPTY;
            TAG_OVERFLOW:   op.cls = CLS_TAG_OVF;
            TAG_FAST_LAST,
            TAG_INVALID_A,
            TAG_INVALID_B:  op.cls = CLS_CLOSE;
            default:        op.cls = CLS_CLOSE;
        endcase
    end

endmodule

FILE: design/ecgfsd_queue.sv
module ecgfsd_queue
    import ecgfsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ecgfsd_op_t    push_op,
    input  logic          pop,
    output ecgfsd_op_t    pop_op,
    output ecgfsd_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    ecgfsd_op_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == CNT_W_Q'(DEPTH));
    assign pop_op      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: design/ecgfsd_back.sv
module ecgfsd_back
    import ecgfsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ecgfsd_qstat_t         qstat,
    input  ecgfsd_op_t            op,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser
);

    logic                burst_reg, burst_next;
    logic                pll_prev_reg, pll_prev_next;
    logic [LEAD_W-1:0]   lead_reg, lead_next;
    logic                pos_reg, pos_next;
    logic                neg_reg, neg_next;
    logic                dc_reg, dc_next;
    logic [CNT_W-1:0]    smp_cnt_reg, smp_cnt_next;
    logic [CNT_W-1:0]    ovf_cnt_reg, ovf_cnt_next;
    logic [CNT_W-1:0]    emp_cnt_reg, emp_cnt_next;
    logic [CNT_W-1:0]    tovf_cnt_reg, tovf_cnt_next;
    logic [CNT_W-1:0]    pll_cnt_reg, pll_cnt_next;
    logic [CNT_W-1:0]    edge_cnt_reg, edge_cnt_next;
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [KIND_W-1:0]   m_user_reg;

    assign pop      = qstat.valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        burst_next    = burst_reg;
        pll_prev_next = pll_prev_reg;
        lead_next     = lead_reg;
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        dc_next       = dc_reg;
        smp_cnt_next  = smp_cnt_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        emp_cnt_next  = emp_cnt_reg;
        tovf_cnt_next = tovf_cnt_reg;
        pll_cnt_next  = pll_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        kind          = KIND_SKIPPED;
        sample        = '0;
        if (!op.is_fifo) begin
            if (op.pll) begin
                pll_cnt_next = pll_cnt_reg + 1'b1;
                if (!pll_prev_reg) begin
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                end
            end
            pll_prev_next = op.pll;
            pos_next      = op.pos;
            neg_next      = op.neg;
            dc_next       = op.dc;
            lead_next     = (op.pos || op.neg || op.dc) ? LEAD_OFF : LEAD_ON;
            priority if (op.ovf) begin
                ovf_cnt_next = ovf_cnt_reg + 1'b1;
                burst_next   = 1'b0;
                kind         = KIND_OVERFLOW;
            end else if (op.drdy) begin
                burst_next = 1'b1;
                kind       = KIND_OPENED;
            end else begin
                burst_next = 1'b0;
                kind       = KIND_NO_DATA;
            end
        end else if (burst_reg) begin
            unique case (op.cls)
                CLS_SAMPLE, CLS_SAMPLE_LAST: begin
                    sample       = op.sample;
                    smp_cnt_next = smp_cnt_reg + 1'b1;
                    kind         = KIND_SAMPLE;
                    if (op.cls == CLS_SAMPLE_LAST) begin
                        burst_next = 1'b0;
                    end
                end
                CLS_FAST: begin
                    kind = KIND_SKIPPED;
                end
                CLS_EMPTY: begin
                    emp_cnt_next = emp_cnt_reg + 1'b1;
                    burst_next   = 1'b0;
                    kind         = KIND_BURST_END;
                end
                CLS_TAG_OVF: begin
                    tovf_cnt_next = tovf_cnt_reg + 1'b1;
                    ovf_cnt_next  = ovf_cnt_reg + 1'b1;
                    burst_next    = 1'b0;
                    kind          = KIND_OVERFLOW;
                end
                default: begin
                    burst_next = 1'b0;
                    kind       = KIND_BURST_END;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg    <= 1'b0;
            pll_prev_reg <= 1'b0;
            lead_reg     <= LEAD_UNKNOWN;
            pos_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            dc_reg       <= 1'b0;
            smp_cnt_reg  <= '0;
            ovf_cnt_reg  <= '0;
            emp_cnt_reg  <= '0;
            tovf_cnt_reg <= '0;
            pll_cnt_reg  <= '0;
            edge_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                burst_reg    <= burst_next;
                pll_prev_reg <= pll_prev_next;
                lead_reg     <= lead_next;
                pos_reg      <= pos_next;
                neg_reg      <= neg_next;
                dc_reg       <= dc_next;
                smp_cnt_reg  <= smp_cnt_next;
                ovf_cnt_reg  <= ovf_cnt_next;
                emp_cnt_reg  <= emp_cnt_next;
                tovf_cnt_reg <= tovf_cnt_next;
                pll_cnt_reg  <= pll_cnt_next;
                edge_cnt_reg <= edge_cnt_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // top three bits of m_tdata are byte padding
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= {3'b000, edge_cnt_next, pll_cnt_next, tovf_cnt_next, emp_cnt_next,
                           ovf_cnt_next, smp_cnt_next, dc_next, neg_next, pos_next,
                           lead_next, sample};
            m_user_reg <= kind;
        end
    end

endmodule

FILE: design/ecg_fifo_status_decoder_unit.sv
// Decodes the word stream of an ECG front end: status words (s_tuser = 0) update the
// PLL-unlock counters and lead-off flags and open or close a FIFO burst; FIFO words
// (s_tuser = 1) are decoded by their tag while a burst is open. Every accepted word
// yields exactly one result transaction: the result kind on m_tuser, the sample, lead
// state, lead-off flags and all running totals on m_tdata. One word per clock is
// sustained while m_tready is high; m_tvalid rises once the word has passed queue and
// output register. A small queue between the input decode and the state update absorbs
// output stalls, so s_tready drops only once QUEUE_DEPTH words wait behind a held result.
module ecg_fifo_status_decoder_unit
    import ecgfsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // word[23:0]
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sample[15:0], lead_state[17:16], pos_lead_off[18], neg_lead_off[19],
    // dc_lead_off[20], sample_total[52:21], overflow_total[84:53],
    // empty_total[116:85], tag_overflow_total[148:117], pll_seen_total[180:149],
    // pll_edge_total[212:181], zero padding[215:213]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser    // kind[2:0]
);

    ecgfsd_qstat_t qstat;
    ecgfsd_op_t    push_op;
    ecgfsd_op_t    pop_op;
    logic          push;
    logic          pop;

    ecgfsd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .push     (push),
        .op       (push_op)
    );

    ecgfsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .qstat   (qstat)
    );

    ecgfsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .op       (pop_op),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: design/ecgfsd_checker.sv
module ecgfsd_checker
    import ecgfsd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser
);

    logic              out_hs;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  smp_total;
    logic [CNT_W-1:0]  emp_total;
    logic [CNT_W-1:0]  smp_last_reg;
    logic [CNT_W-1:0]  emp_last_reg;

    assign out_hs    = m_tvalid && m_tready;
    assign kind      = m_tuser;
    assign smp_total = m_tdata[52:21];
    assign emp_total = m_tdata[116:85];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_last_reg <= '0;
            emp_last_reg <= '0;
        end else if (out_hs) begin
            smp_last_reg <= smp_total;
            emp_last_reg <= emp_total;
        end
    end

    // sample total moves by one exactly on sample results
    a_smp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_hs |-> (smp_total == ((kind == KIND_SAMPLE) ? smp_last_reg + 1'b1 : smp_last_reg)))
        else $error("sample_total step mismatch");

    // empty total can only move on a burst-end result
    a_emp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_hs && kind != KIND_BURST_END) |-> (emp_total == emp_last_reg))
        else $error("empty_total moved outside burst end");

    a_smp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && kind != KIND_SAMPLE) |-> (m_tdata[15:0] == '0))
        else $error("sample nonzero on non-sample result");

    a_lead_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[17:16] == LEAD_UNKNOWN) |-> (m_tdata[20:18] == '0))
        else $error("lead flags set while lead state unknown");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind ecg_fifo_status_decoder_unit ecgfsd_checker u_ecgfsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/ecg_fifo_status_decoder_unit_tb.sv
`timescale 1ns / 100ps

module ecg_fifo_status_decoder_unit_tb;
    import ecgfsd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_WORDS  = 925;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] smp;
        logic [LEAD_W-1:0]   lead;
        logic                pos;
        logic                neg;
        logic                dc;
        logic [CNT_W-1:0]    samples;
        logic [CNT_W-1:0]    overflows;
        logic [CNT_W-1:0]    empties;
        logic [CNT_W-1:0]    tag_ovfs;
        logic [CNT_W-1:0]    pll_seen;
        logic [CNT_W-1:0]    pll_edges;
    } ecg_res_t;

    typedef struct packed {
        logic                is_fifo;
        logic [WORD_W-1:0]   word;
        logic                pinned;
        logic [KIND_W-1:0]   kind;
        logic [SAMPLE_W-1:0] smp;
    } word_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;

    // decoder state mirror
    logic             burst_open;
    logic             pll_prev;
    logic [LEAD_W-1:0] lead_st;
    logic             pos_flag, neg_flag, dc_flag;
    logic [CNT_W-1:0] sample_cnt, ovf_cnt, empty_cnt, tag_ovf_cnt, pll_seen_cnt, pll_edge_cnt;

    ecg_res_t pending_results[$];

    int  errors = 0;
    int  mismatches = 0;
    int  n_words;
    int  n_results = 0;
    int  kind_seen[8] = '{default: 0};
    int  cycle_cnt = 0;
    bit  src_idle_en;
    bit  snk_idle_en = 1'b1;
    bit  long_hold_req;

    word_row_t dir_rows [DIR_ROWS] = '{
        '{1'b1, 24'h000000, 1'b1, KIND_SKIPPED,   16'h0000},  // FIFO word before any burst
        '{1'b0, 24'h000000, 1'b1, KIND_NO_DATA,   16'h0000},
        '{1'b0, 24'hFFFFFF, 1'b1, KIND_OVERFLOW,  16'h0000},
        '{1'b0, 24'h800000, 1'b1, KIND_OPENED,    16'h0000},
        '{1'b1, 24'h7FFFC0, 1'b1, KIND_SAMPLE,    16'h7FFF},  // most positive sample
        '{1'b1, 24'h800000, 1'b1, KIND_SAMPLE,    16'h8000},  // most negative sample
        '{1'b1, 24'h123408, 1'b1, KIND_SKIPPED,   16'h0000},  // fast tag
        '{1'b1, 24'hFFFFC7, 1'b1, KIND_SAMPLE,    16'hFFFF},
        '{1'b1, 24'h000010, 1'b1, KIND_SAMPLE,    16'h0000},  // valid-last closes
        '{1'b1, 24'hABCD00, 1'b1, KIND_SKIPPED,   16'h0000},
        '{1'b0, 24'h800100, 1'b1, KIND_OPENED,    16'h0000},  // PLL rising edge
        '{1'b1, 24'h555518, 1'b1, KIND_BURST_END, 16'h0000},  // fast-last
        '{1'b0, 24'h800100, 1'b0, KIND_OPENED,    16'h0000},  // PLL held, no edge
        '{1'b1, 24'h000020, 1'b1, KIND_BURST_END, 16'h0000},
        '{1'b0, 24'h900000, 1'b0, KIND_OPENED,    16'h0000},  // DC lead-off
        '{1'b1, 24'hFFFFE8, 1'b1, KIND_BURST_END, 16'h0000},
        '{1'b0, 24'h80000C, 1'b0, KIND_OPENED,    16'h0000},  // positive lead-off
        '{1'b1, 24'h000030, 1'b1, KIND_BURST_END, 16'h0000},  // empty tag
        '{1'b0, 24'h800003, 1'b0, KIND_OPENED,    16'h0000},  // negative lead-off
        '{1'b1, 24'hFFFFFF, 1'b1, KIND_OVERFLOW,  16'h0000},  // overflow tag
        '{1'b0, 24'h800000, 1'b1, KIND_OPENED,    16'h0000},
        '{1'b1, 24'h3C0A57, 1'b0, KIND_SAMPLE,    16'h0000},
        '{1'b0, 24'h000000, 1'b1, KIND_NO_DATA,   16'h0000},
        '{1'b0, 24'hC00000, 1'b1, KIND_OVERFLOW,  16'h0000},  // overflow wins over data-ready
        '{1'b1, 24'hFFFFFF, 1'b1, KIND_SKIPPED,   16'h0000}
    };

    ecg_fifo_status_decoder_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("ecg_fifo_status_decoder_unit_tb failed");
            $finish;
        end
    end

    function automatic ecg_res_t decode_word(input logic is_fifo, input logic [WORD_W-1:0] w);
        ecg_res_t r;
        logic [TAG_W-1:0] tag;
        r = '0;
        if (!is_fifo) begin
            if (w[PLL_BIT]) begin
                pll_seen_cnt++;
                if (!pll_prev)
                    pll_edge_cnt++;
            end
            pll_prev = w[PLL_BIT];
            pos_flag = |w[3:2];
            neg_flag = |w[1:0];
            dc_flag  = w[DC_LEADOFF_BIT];
            lead_st  = (pos_flag | neg_flag | dc_flag) ? LEAD_OFF : LEAD_ON;
            if (w[OVERFLOW_BIT]) begin
                ovf_cnt++;
                burst_open = 1'b0;
                r.kind = KIND_OVERFLOW;
            end else if (w[DATA_READY_BIT]) begin
                burst_open = 1'b1;
                r.kind = KIND_OPENED;
            end else begin
                burst_open = 1'b0;
                r.kind = KIND_NO_DATA;
            end
        end else if (!burst_open) begin
            r.kind = KIND_SKIPPED;
        end else begin
            tag = w[5:3];
            case (tag)
                TAG_VALID, TAG_VALID_LAST: begin
                    // 18-bit sample in [23:6], arithmetic >> 2 keeps its top 16 bits
                    r.smp = w[23:8];
                    sample_cnt++;
                    r.kind = KIND_SAMPLE;
                    if (tag == TAG_VALID_LAST)
                        burst_open = 1'b0;
                end
                TAG_FAST: r.kind = KIND_SKIPPED;
                TAG_EMPTY: begin
                    empty_cnt++;
                    burst_open = 1'b0;
                    r.kind = KIND_BURST_END;
                end
                TAG_OVERFLOW: begin
                    tag_ovf_cnt++;
                    ovf_cnt++;
                    burst_open = 1'b0;
                    r.kind = KIND_OVERFLOW;
                end
                default: begin
                    burst_open = 1'b0;
                    r.kind = KIND_BURST_END;
                end
            endcase
        end
        r.lead      = lead_st;
        r.pos       = pos_flag;
        r.neg       = neg_flag;
        r.dc        = dc_flag;
        r.samples   = sample_cnt;
        r.overflows = ovf_cnt;
        r.empties   = empty_cnt;
        r.tag_ovfs  = tag_ovf_cnt;
        r.pll_seen  = pll_seen_cnt;
        r.pll_edges = pll_edge_cnt;
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input word_row_t row);
        int gap;
        ecg_res_t want;
        gap = src_idle_en ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 39) == 0)
            src_idle_en = !src_idle_en;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.is_fifo;
        s_tdata  <= row.word;
        do @(posedge aclk); while (!s_tready);
        want = decode_word(row.is_fifo, row.word);
        if (row.pinned) begin
            want.kind = row.kind;
            want.smp  = row.smp;
        end
        pending_results.push_back(want);
        n_words++;
        @(negedge aclk);
    endtask

    task automatic send_random(input logic is_fifo, input logic [WORD_W-1:0] w);
        word_row_t row;
        row = '0;
        row.is_fifo = is_fifo;
        row.word    = w;
        send_word(row);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d field %s: expected %0h, got %0h", n_results, name, want, got);
        end
    endtask

    initial begin : result_sink
        int stall;
        ecg_res_t want;
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = 0;
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall = LONG_HOLD;
            end else if (snk_idle_en) begin
                stall = $urandom_range(0, 15);
            end
            if ($urandom_range(0, 31) == 0)
                snk_idle_en = !snk_idle_en;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h %h", m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("kind",           want.kind,      m_tuser);
                check_field("sample",         want.smp,       m_tdata[15:0]);
                check_field("lead_state",     want.lead,      m_tdata[17:16]);
                check_field("pos_lead_off",   want.pos,       m_tdata[18]);
                check_field("neg_lead_off",   want.neg,       m_tdata[19]);
                check_field("dc_lead_off",    want.dc,        m_tdata[20]);
                check_field("sample_total",   want.samples,   m_tdata[52:21]);
                check_field("overflow_total", want.overflows, m_tdata[84:53]);
                check_field("empty_total",    want.empties,   m_tdata[116:85]);
                check_field("tag_ovf_total",  want.tag_ovfs,  m_tdata[148:117]);
                check_field("pll_seen_total", want.pll_seen,  m_tdata[180:149]);
                check_field("pll_edge_total", want.pll_edges, m_tdata[212:181]);
                kind_seen[want.kind]++;
            end
            n_results++;
            @(negedge aclk);
        end
    end

    initial begin : word_source
        logic [WORD_W-1:0] w;
        logic [TAG_W-1:0]  tag;
        int  burst_len;
        int  pick;
        bit  hold_done;
        bit  pause_done;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        burst_open = 1'b0;
        pll_prev   = 1'b0;
        lead_st    = LEAD_UNKNOWN;
        pos_flag = 1'b0;
        neg_flag = 1'b0;
        dc_flag  = 1'b0;
        sample_cnt   = '0;
        ovf_cnt      = '0;
        empty_cnt    = '0;
        tag_ovf_cnt  = '0;
        pll_seen_cnt = '0;
        pll_edge_cnt = '0;
        n_words = 0;
        src_idle_en = 1'b1;
        long_hold_req = 1'b0;
        hold_done = 1'b0;
        pause_done = 1'b0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i]);
        wait_drained();

        while (n_words < DIR_ROWS + RANDOM_WORDS) begin
            if (!hold_done && n_words > 350) begin
                // stall the result side while words keep coming
                hold_done = 1'b1;
                src_idle_en = 1'b0;
                long_hold_req = 1'b1;
            end
            if (!pause_done && n_words > 650) begin
                pause_done = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                w = WORD_W'($urandom);
                w[DATA_READY_BIT] = 1'b1;
                w[OVERFLOW_BIT] = ($urandom_range(0, 15) == 0);
                if ($urandom_range(0, 3) != 0) begin
                    w[3:0] = '0;
                    w[DC_LEADOFF_BIT] = 1'b0;
                end
                send_random(1'b0, w);
                burst_len = $urandom_range(0, 12);
                repeat (burst_len) begin
                    w = WORD_W'($urandom);
                    pick = $urandom_range(0, 7);
                    if (pick < 5)
                        w[5:3] = TAG_VALID;
                    else if (pick < 7)
                        w[5:3] = TAG_FAST;
                    send_random(1'b1, w);
                end
                w = WORD_W'($urandom);
                case ($urandom_range(0, 5))
                    0: tag = TAG_VALID_LAST;
                    1: tag = TAG_FAST_LAST;
                    2: tag = TAG_INVALID_A;
                    3: tag = TAG_INVALID_B;
                    4: tag = TAG_EMPTY;
                    default: tag = TAG_OVERFLOW;
                endcase
                w[5:3] = tag;
                send_random(1'b1, w);
                // trailing words after the burst closed should come back as skipped results
                if ($urandom_range(0, 3) == 0)
                    send_random(1'b1, WORD_W'($urandom));
            end else begin
                send_random(1'($urandom_range(0, 1)), WORD_W'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d mismatches", n_words, n_results, errors);
        $display("kinds: sample %0d skip %0d end %0d ovf %0d open %0d idle %0d",
                 kind_seen[KIND_SAMPLE], kind_seen[KIND_SKIPPED], kind_seen[KIND_BURST_END],
                 kind_seen[KIND_OVERFLOW], kind_seen[KIND_OPENED], kind_seen[KIND_NO_DATA]);
        if (errors == 0 && pending_results.size() == 0)
            $display("ecg_fifo_status_decoder_unit_tb passed");
        else
            $display("ecg_fifo_status_decoder_unit_tb failed");
        $finish;
    end

endmodule
